[rtl/tfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Tile frame decoder package
// Shared result type, frame kind codes and sequencer states.
// -----------------------------------------------------------------------------
package tfd_pkg;

	localparam logic [2:0] KIND_SQUARE     = 3'd0;
	localparam logic [2:0] KIND_RLE        = 3'd1;
	localparam logic [2:0] KIND_LEFT_TRI   = 3'd2;
	localparam logic [2:0] KIND_RIGHT_TRI  = 3'd3;
	localparam logic [2:0] KIND_LEFT_TRAP  = 3'd4;
	localparam logic [2:0] KIND_RIGHT_TRAP = 3'd5;

	typedef struct packed {
		logic [4:0] pixel_x;
		logic [4:0] pixel_y;
		logic       opaque;
		logic [7:0] color_index;
		logic       run_last;
		logic       frame_done;
		logic       frame_error;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETTLE,
		ST_TAKE,
		ST_RUN,
		ST_ROWCHK,
		ST_ENDCHK,
		ST_ERR,
		ST_FLUSH
	} seq_state_t;

endpackage
`default_nettype wire

[rtl/tile_frame_decoder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Flow: each result waits in a pending register and moves to the output register when the
// next result is made or the byte is flushed; the output register holds it while m_tready is low.
// s_tready is high only in idle, so a new byte is taken only once every result of the last one
// has been passed on; a stall on the output holds the sequencer back.
// Reset: arst_n clears the sequencer to idle, the frame kind to zero and the row to the top.
// -----------------------------------------------------------------------------
// Tile frame decoder
// Turns the encoded bytes of one square tile frame into a stream of pixels.
// -----------------------------------------------------------------------------
module tile_frame_decoder_unit #(
	parameter int TILE_SIDE = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tuser,   // frame_start
	input  logic        s_tlast,   // data_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // pixel_x, pixel_y, color_index, zero fill
	output logic [2:0]  m_tuser,   // opaque, frame_done, frame_error
	output logic        m_tlast    // run_last
);
	import tfd_pkg::*;

	localparam int HALF = TILE_SIDE / 2;
	localparam int CW   = $clog2(TILE_SIDE) + 1;
	localparam int RW   = $clog2(TILE_SIDE);
	localparam int CMPW = (CW > 8) ? CW : 8;

	typedef struct packed {
		logic [CW-1:0] lead;
		logic [CW-1:0] count;
		logic          skip_pre;
		logic          skip_post;
	} shape_t;

	function automatic shape_t shape_f(input logic [RW-1:0] y, input logic [2:0] k);
		shape_t        s;
		logic          bottom;
		logic          left;
		logic          right;
		logic          tri_k;
		logic          odd;
		logic [CW-1:0] i;
		logic [CW-1:0] two_i;
		bottom = (CW'(y) >= CW'(HALF));
		i      = bottom ? (CW'(TILE_SIDE) - CW'(y)) : (CW'(HALF) - CW'(y));
		two_i  = i << 1;
		odd    = i[0];
		left   = (k == KIND_LEFT_TRI) || (k == KIND_LEFT_TRAP);
		right  = (k == KIND_RIGHT_TRI) || (k == KIND_RIGHT_TRAP);
		tri_k  = (k == KIND_LEFT_TRI) || (k == KIND_RIGHT_TRI);
		s.lead      = '0;
		s.count     = CW'(TILE_SIDE);
		s.skip_pre  = 1'b0;
		s.skip_post = 1'b0;
		if ((left || right) && (bottom || tri_k)) begin
			s.count = bottom ? two_i : (CW'(TILE_SIDE) - two_i);
			if (left) begin
				s.lead     = bottom ? (CW'(TILE_SIDE) - two_i) : two_i;
				s.skip_pre = odd;
			end else begin
				s.skip_post = odd;
			end
		end
		return s;
	endfunction

	seq_state_t    state_q, state_d;
	logic [2:0]    frame_kind_q;
	logic [2:0]    kind_q, kind_d;
	logic [7:0]    byte_q, byte_d;
	logic          end_q, end_d;
	logic          taken_q, taken_d;
	logic [CW-1:0] column_q, column_d;
	logic [RW-1:0] row_q, row_d;
	logic [1:0]    skip_q, skip_d;
	logic [6:0]    literal_q, literal_d;
	logic [7:0]    run_q, run_d;
	logic          dec_q, dec_d;
	res_t          pend_q, pend_d;
	logic          pend_v_q, pend_v_d;

	shape_t        sh_cur;
	shape_t        sh_next;
	shape_t        sh_top;
	logic          in_range;
	logic [CW-1:0] rest;
	logic [7:0]    neg_run;
	logic          can_push;
	logic          do_emit;
	res_t          new_res;
	logic          push_v;
	res_t          push_data;
	logic          push_ready;
	res_t          out_data;

	assign sh_cur   = shape_f(row_q, kind_q);
	assign sh_next  = shape_f(RW'(row_q - 1'b1), kind_q);
	assign sh_top   = shape_f(RW'(TILE_SIDE - 1), frame_kind_q);
	assign in_range = (column_q >= sh_cur.lead) &&
		(column_q < CW'(sh_cur.lead + sh_cur.count));
	assign rest     = (column_q < CW'(TILE_SIDE)) ? CW'(CW'(TILE_SIDE) - column_q) : '0;
	assign neg_run  = 8'(8'd0 - byte_q);
	assign can_push = !pend_v_q || push_ready;
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		byte_d    = byte_q;
		end_d     = end_q;
		taken_d   = taken_q;
		column_d  = column_q;
		row_d     = row_q;
		skip_d    = skip_q;
		literal_d = literal_q;
		run_d     = run_q;
		dec_d     = dec_q;
		pend_d    = pend_q;
		pend_v_d  = pend_v_q;
		do_emit   = 1'b0;
		new_res   = '0;
		push_v    = 1'b0;
		push_data = pend_q;
		new_res.pixel_x = 5'(column_q);
		new_res.pixel_y = 5'(row_q);

		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					byte_d   = s_tdata;
					end_d    = s_tlast;
					taken_d  = 1'b0;
					pend_v_d = 1'b0;
					if (s_tuser) begin
						kind_d    = frame_kind_q;
						row_d     = RW'(TILE_SIDE - 1);
						column_d  = '0;
						literal_d = '0;
						dec_d     = 1'b1;
						skip_d    = (frame_kind_q != KIND_RLE && sh_top.skip_pre) ?
							2'd2 : 2'd0;
						state_d   = (frame_kind_q != KIND_RLE) ? ST_SETTLE : ST_TAKE;
					end else begin
						state_d = dec_q ? ST_TAKE : ST_ENDCHK;
					end
				end
			end
			ST_SETTLE: begin
				if (!dec_q || skip_q != 2'd0) begin
					state_d = taken_q ? ST_ENDCHK : ST_TAKE;
				end else if (column_q >= CW'(TILE_SIDE)) begin
					if (row_q == '0) begin
						pend_d.frame_done = pend_v_q;
						dec_d = 1'b0;
					end else begin
						row_d    = RW'(row_q - 1'b1);
						column_d = '0;
						skip_d   = (sh_cur.skip_post || sh_next.skip_pre) ? 2'd2 : 2'd0;
					end
				end else if (in_range) begin
					state_d = taken_q ? ST_ENDCHK : ST_TAKE;
				end else if (can_push) begin
					do_emit  = 1'b1;
					column_d = CW'(column_q + 1'b1);
				end
			end
			ST_TAKE: begin
				if (!dec_q) begin
					state_d = ST_ENDCHK;
				end else if (kind_q != KIND_RLE) begin
					if (skip_q != 2'd0) begin
						skip_d  = 2'(skip_q - 1'b1);
						taken_d = 1'b1;
						state_d = ST_SETTLE;
					end else if (in_range) begin
						if (can_push) begin
							do_emit             = 1'b1;
							new_res.opaque      = 1'b1;
							new_res.color_index = byte_q;
							column_d            = CW'(column_q + 1'b1);
							taken_d             = 1'b1;
							state_d             = ST_SETTLE;
						end
					end else begin
						taken_d = 1'b1;
						state_d = ST_SETTLE;
					end
				end else if (literal_q != '0) begin
					if (can_push) begin
						do_emit             = 1'b1;
						new_res.opaque      = 1'b1;
						new_res.color_index = byte_q;
						column_d            = CW'(column_q + 1'b1);
						literal_d           = 7'(literal_q - 1'b1);
						state_d             = ST_ROWCHK;
					end
				end else if (byte_q[7]) begin
					if (CMPW'(neg_run) > CMPW'(rest)) begin
						state_d = ST_ERR;
					end else begin
						run_d   = neg_run;
						state_d = ST_RUN;
					end
				end else if (byte_q != 8'd0) begin
					if (CMPW'(byte_q) > CMPW'(rest)) begin
						state_d = ST_ERR;
					end else begin
						literal_d = byte_q[6:0];
						state_d   = ST_ROWCHK;
					end
				end else begin
					state_d = ST_ROWCHK;
				end
			end
			ST_RUN: begin
				if (run_q == 8'd0) begin
					state_d = ST_ROWCHK;
				end else if (can_push) begin
					do_emit  = 1'b1;
					column_d = CW'(column_q + 1'b1);
					run_d    = 8'(run_q - 1'b1);
				end
			end
			ST_ROWCHK: begin
				if (dec_q && literal_q == '0 && column_q >= CW'(TILE_SIDE)) begin
					if (row_q == '0) begin
						pend_d.frame_done = pend_v_q;
						dec_d = 1'b0;
					end else begin
						row_d    = RW'(row_q - 1'b1);
						column_d = '0;
						skip_d   = (sh_cur.skip_post || sh_next.skip_pre) ? 2'd2 : 2'd0;
					end
				end
				state_d = ST_ENDCHK;
			end
			ST_ENDCHK: begin
				state_d = (end_q && dec_q) ? ST_ERR : ST_FLUSH;
			end
			ST_ERR: begin
				if (can_push) begin
					do_emit             = 1'b1;
					new_res.pixel_x     = '0;
					new_res.pixel_y     = '0;
					new_res.frame_error = 1'b1;
					dec_d               = 1'b0;
					skip_d              = '0;
					literal_d           = '0;
					state_d             = ST_ENDCHK;
				end
			end
			ST_FLUSH: begin
				if (!pend_v_q) begin
					state_d = ST_IDLE;
				end else if (push_ready) begin
					push_v             = 1'b1;
					push_data.run_last = 1'b1;
					pend_v_d           = 1'b0;
					state_d            = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (do_emit) begin
			push_v   = pend_v_q;
			pend_d   = new_res;
			pend_v_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			frame_kind_q <= KIND_SQUARE;
			kind_q       <= KIND_SQUARE;
			column_q     <= '0;
			row_q        <= RW'(TILE_SIDE - 1);
			skip_q       <= '0;
			literal_q    <= '0;
			run_q        <= '0;
			dec_q        <= 1'b0;
			taken_q      <= 1'b0;
			pend_v_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			kind_q    <= kind_d;
			column_q  <= column_d;
			row_q     <= row_d;
			skip_q    <= skip_d;
			literal_q <= literal_d;
			run_q     <= run_d;
			dec_q     <= dec_d;
			taken_q   <= taken_d;
			pend_v_q  <= pend_v_d;
			if (cfg_we) begin
				frame_kind_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_d;
		end_q  <= end_d;
		pend_q <= pend_d;
	end

	tfd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_v),
		.in_data   (push_data),
		.in_ready  (push_ready),
		.out_valid (m_tvalid),
		.out_data  (out_data),
		.out_ready (m_tready)
	);

	assign m_tdata = {6'd0, out_data.color_index, out_data.pixel_y, out_data.pixel_x};
	assign m_tuser = {out_data.frame_error, out_data.frame_done, out_data.opaque};
	assign m_tlast = out_data.run_last;

endmodule
`default_nettype wire

[rtl/tfd_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Tile frame decoder output register
// One-entry register that holds a finished result until the sink takes it.
// -----------------------------------------------------------------------------
module tfd_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  tfd_pkg::res_t in_data,
	output logic          in_ready,
	output logic          out_valid,
	output tfd_pkg::res_t out_data,
	input  logic          out_ready
);
	import tfd_pkg::*;

	logic valid_q;
	res_t data_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= in_data;
		end
	end

endmodule
`default_nettype wire

[bench/tfd_pixel_checker.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Tile frame decoder pixel checker
// Watches the configuration port and both stream channels of the decoder. Every
// byte taken on the input is decoded by a shadow decoder written here, and the
// pixels it yields are queued. Each pixel on the output is compared with the
// oldest queued pixel; mismatches are counted and handed to the top.
// -----------------------------------------------------------------------------
module tfd_pixel_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tuser,   // frame_start
	input  logic        s_tlast,   // data_end
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // pixel_x, pixel_y, color_index, zero fill
	input  logic [2:0]  m_tuser,   // opaque, frame_done, frame_error
	input  logic        m_tlast,   // run_last
	output int          mismatches,
	output int          outstanding
);
	import tfd_pkg::*;

	localparam int SIDE = 32;
	localparam int HALF = SIDE / 2;

	logic [2:0] kind_reg = KIND_SQUARE;
	logic [2:0] kind_now = KIND_SQUARE;
	int col = 0;
	int row_y = SIDE - 1;
	int skip_n = 0;
	int lit_n = 0;
	bit decoding = 1'b0;
	res_t step_out[$];
	res_t pending_pixels[$];
	res_t got;
	res_t want;

	task automatic row_shape(input int y, output int lead, output int span,
			output bit pre, output bit post);
		int i;
		bit bottom;
		bit lft;
		bit rgt;
		bit slanted;
		bottom = y >= HALF;
		i = bottom ? SIDE - y : HALF - y;
		lft = kind_now == KIND_LEFT_TRI || kind_now == KIND_LEFT_TRAP;
		rgt = kind_now == KIND_RIGHT_TRI || kind_now == KIND_RIGHT_TRAP;
		slanted = kind_now == KIND_LEFT_TRI || kind_now == KIND_RIGHT_TRI;
		lead = 0;
		span = SIDE;
		pre = 1'b0;
		post = 1'b0;
		if ((lft || rgt) && (bottom || slanted)) begin
			span = bottom ? 2 * i : SIDE - 2 * i;
			if (lft) begin
				lead = bottom ? SIDE - 2 * i : 2 * i;
				pre = i[0];
			end else begin
				post = i[0];
			end
		end
	endtask

	task automatic push_pixel(input int x, input int y, input bit opq, input logic [7:0] c,
			input bit err);
		res_t p;
		p = '0;
		p.pixel_x = x[4:0];
		p.pixel_y = y[4:0];
		p.opaque = opq;
		p.color_index = c;
		p.frame_error = err;
		step_out = {step_out, p};
	endtask

	task automatic fail_frame();
		push_pixel(0, 0, 1'b0, 8'h00, 1'b1);
		decoding = 1'b0;
		skip_n = 0;
		lit_n = 0;
	endtask

	task automatic close_row();
		int lead;
		int span;
		bit pre;
		bit post;
		bit pre_nx;
		bit post_nx;
		res_t tail;
		if (row_y == 0) begin
			if (step_out.size() > 0) begin
				tail = step_out[step_out.size() - 1];
				tail.frame_done = 1'b1;
				step_out[step_out.size() - 1] = tail;
			end
			decoding = 1'b0;
		end else begin
			row_shape(row_y, lead, span, pre, post);
			row_y--;
			col = 0;
			row_shape(row_y, lead, span, pre_nx, post_nx);
			skip_n = (post || pre_nx) ? 2 : 0;
		end
	endtask

	// Emits the fixed transparent edge pixels up to the next pixel that needs a byte.
	task automatic pad_transparent();
		int lead;
		int span;
		bit pre;
		bit post;
		while (decoding && skip_n == 0) begin
			if (col >= SIDE) begin
				close_row();
			end else begin
				row_shape(row_y, lead, span, pre, post);
				if (col >= lead && col < lead + span)
					break;
				push_pixel(col, row_y, 1'b0, 8'h00, 1'b0);
				col++;
			end
		end
	endtask

	task automatic take_fixed(input logic [7:0] b);
		int lead;
		int span;
		bit pre;
		bit post;
		if (skip_n > 0) begin
			skip_n--;
		end else begin
			row_shape(row_y, lead, span, pre, post);
			if (col >= lead && col < lead + span) begin
				push_pixel(col, row_y, 1'b1, b, 1'b0);
				col++;
			end
		end
		pad_transparent();
	endtask

	task automatic take_rle(input logic [7:0] b);
		int rest;
		int n;
		bit bad;
		rest = (col < SIDE) ? SIDE - col : 0;
		bad = 1'b0;
		if (lit_n > 0) begin
			push_pixel(col, row_y, 1'b1, b, 1'b0);
			col++;
			lit_n--;
		end else if (b[7]) begin
			n = 256 - int'(b);
			if (n > rest) begin
				bad = 1'b1;
			end else begin
				repeat (n) begin
					push_pixel(col, row_y, 1'b0, 8'h00, 1'b0);
					col++;
				end
			end
		end else if (b != 8'h00) begin
			if (int'(b) > rest)
				bad = 1'b1;
			else
				lit_n = int'(b);
		end
		if (bad)
			fail_frame();
		else if (decoding && lit_n == 0 && col >= SIDE)
			close_row();
	endtask

	task automatic decode_byte(input logic [7:0] b, input bit start, input bit last);
		int lead;
		int span;
		bit pre;
		bit post;
		res_t tail;
		step_out.delete();
		if (start) begin
			kind_now = kind_reg;
			row_y = SIDE - 1;
			col = 0;
			lit_n = 0;
			decoding = 1'b1;
			row_shape(row_y, lead, span, pre, post);
			skip_n = (kind_now != KIND_RLE && pre) ? 2 : 0;
			if (kind_now != KIND_RLE)
				pad_transparent();
		end
		if (decoding) begin
			if (kind_now == KIND_RLE)
				take_rle(b);
			else
				take_fixed(b);
		end
		if (last && decoding)
			fail_frame();
		if (step_out.size() > 0) begin
			tail = step_out[step_out.size() - 1];
			tail.run_last = 1'b1;
			step_out[step_out.size() - 1] = tail;
		end
		pending_pixels = {pending_pixels, step_out};
	endtask

	task automatic report_mismatch(input string what, input res_t exp_px, input res_t act_px);
		$write("%0t ns: %s: expected x=%0d y=%0d opq=%0b color=%02h",
			$realtime, what, exp_px.pixel_x, exp_px.pixel_y, exp_px.opaque,
			exp_px.color_index);
		$write(" last=%0b done=%0b err=%0b", exp_px.run_last, exp_px.frame_done,
			exp_px.frame_error);
		$display(", got x=%0d y=%0d opq=%0b color=%02h last=%0b done=%0b err=%0b",
			act_px.pixel_x, act_px.pixel_y, act_px.opaque, act_px.color_index,
			act_px.run_last, act_px.frame_done, act_px.frame_error);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_reg = KIND_SQUARE;
			kind_now = KIND_SQUARE;
			col = 0;
			row_y = SIDE - 1;
			skip_n = 0;
			lit_n = 0;
			decoding = 1'b0;
			pending_pixels.delete();
			outstanding = 0;
		end else begin
			if (cfg_we)
				kind_reg = cfg_wdata;
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tuser, s_tlast);
			if (m_tvalid && m_tready) begin
				got = '0;
				got.pixel_x = m_tdata[4:0];
				got.pixel_y = m_tdata[9:5];
				got.color_index = m_tdata[17:10];
				got.opaque = m_tuser[0];
				got.frame_done = m_tuser[1];
				got.frame_error = m_tuser[2];
				got.run_last = m_tlast;
				if (pending_pixels.size() == 0) begin
					report_mismatch("pixel with none expected", '0, got);
				end else begin
					want = pending_pixels.pop_front();
					if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
							got.opaque !== want.opaque ||
							got.color_index !== want.color_index ||
							got.run_last !== want.run_last ||
							got.frame_done !== want.frame_done ||
							got.frame_error !== want.frame_error)
						report_mismatch("pixel differs", want, got);
				end
			end
			outstanding = pending_pixels.size();
		end
	end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Tile frame decoder regression
// Feeds encoded tile frames of every kind to the decoder: a short directed set
// covering the field extremes and error cases, then random frames, most of them
// cut short or with overlong runs, some well formed. Both stream sides
// idle at random, and the pixel side holds off for long stretches so that the
// decoder backs up. A separate checker predicts and compares every pixel.
// -----------------------------------------------------------------------------
module testbench;
	import tfd_pkg::*;

	localparam int SIDE = 32;
	localparam int RANDOM_ITEMS = 240;
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int QUIET_LIMIT = 2000;

	typedef enum int {RLE_WHOLE, RLE_CUT, RLE_OVERRUN} rle_plan_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_wdata = KIND_SQUARE;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tready = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [23:0] m_tdata;
	wire  [2:0]  m_tuser;
	wire         m_tlast;
	int          fail_count;
	int          expected_count;
	int          quiet_cycles = 0;
	int          fed_items = 0;
	bit          sender_idles = 1'b0;
	bit          sink_stalls = 1'b0;
	bit          hold_off_req = 1'b0;

	tile_frame_decoder_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	tfd_pixel_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.mismatches  (fail_count),
		.outstanding (expected_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tile_frame_decoder_unit regression: fail");
			$finish;
		end
	end

	initial begin : pixel_sink
		int span;
		int pick;
		bit level;
		forever begin
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				pick = $urandom_range(0, 99);
				if (!sink_stalls || pick < 65) begin
					level = 1'b1;
					span = $urandom_range(1, 10);
				end else if (pick < 93) begin
					level = 1'b0;
					span = $urandom_range(1, 3);
				end else begin
					level = 1'b0;
					span = $urandom_range(10, 40);
				end
				m_tready <= level;
				repeat (span) @(posedge clk);
			end
		end
	end

	function automatic int sender_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (!sender_idles || pick < 60)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_item(input logic [7:0] b, input bit start, input bit last);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= start;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		wait (expected_count == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_kind(input logic [2:0] k);
		cfg_we <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic fixed_frame(input int len, input bit close);
		int n;
		for (n = 0; n < len; n++)
			send_item(8'($urandom), n == 0, close && n == len - 1);
		fed_items += len;
	endtask

	// Builds rows of transparent and literal runs; the plan decides how the frame ends.
	task automatic rle_frame(input rle_plan_t plan, input int rows);
		logic [7:0] seq[$];
		int left;
		int n;
		int r;
		int pick;
		int cut;
		bit close;
		for (r = 0; r < rows; r++) begin
			left = SIDE;
			while (left > 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 5) begin
					seq = {seq, 8'h00};
				end else if (pick < 55) begin
					n = ($urandom_range(0, 1) == 1) ? left : $urandom_range(1, left);
					seq = {seq, 8'(256 - n)};
					left -= n;
				end else begin
					n = $urandom_range(1, (left < 4) ? left : 4);
					seq = {seq, 8'(n)};
					repeat (n) seq = {seq, 8'($urandom)};
					left -= n;
				end
			end
		end
		if (plan == RLE_OVERRUN) begin
			n = $urandom_range(0, 31);
			if (n > 0)
				seq = {seq, 8'(256 - n)};
			left = SIDE - n;
			if ($urandom_range(0, 1) == 1)
				seq = {seq, 8'(256 - $urandom_range(left + 1, 128))};
			else
				seq = {seq, 8'($urandom_range(left + 1, 127))};
		end
		if (plan == RLE_CUT) begin
			cut = $urandom_range(1, seq.size());
			seq = seq[0:cut - 1];
			close = $urandom_range(0, 3) != 0;
		end else begin
			close = $urandom_range(0, 1) == 1;
		end
		foreach (seq[k])
			send_item(seq[k], k == 0, close && k == seq.size() - 1);
		fed_items += seq.size();
	endtask

	initial begin : stimulus
		logic [2:0] kind;
		int pick;
		int r;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bytes outside a frame are dropped; the square kind is the reset value.
		send_item(8'h55, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);
		drain();
		write_kind(KIND_RLE);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h12, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h7F, 1'b0, 1'b0);
		send_item(8'hE0, 1'b1, 1'b0);
		send_item(8'h01, 1'b0, 1'b0);
		send_item(8'hAB, 1'b0, 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h20, 1'b0, 1'b0);
		send_item(8'h02, 1'b1, 1'b0);
		send_item(8'h11, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
		drain();
		write_kind(KIND_LEFT_TRI);
		send_item(8'h33, 1'b1, 1'b1);
		drain();
		write_kind(KIND_RIGHT_TRI);
		send_item(8'h44, 1'b1, 1'b0);
		send_item(8'h45, 1'b0, 1'b1);
		drain();
		write_kind(KIND_LEFT_TRAP);
		send_item(8'hC3, 1'b1, 1'b0);
		send_item(8'h3C, 1'b0, 1'b1);
		drain();
		write_kind(KIND_RIGHT_TRAP);
		send_item(8'h5A, 1'b1, 1'b1);

		while (fed_items < RANDOM_ITEMS) begin
			kind = 3'($urandom_range(0, 7));
			drain();
			sender_idles = $urandom_range(0, 3) != 0;
			sink_stalls = $urandom_range(0, 3) != 0;
			write_kind(kind);
			if (kind == KIND_RLE) begin
				pick = $urandom_range(0, 99);
				if (pick < 30)
					rle_frame(RLE_WHOLE, $urandom_range(2, 6));
				else if (pick < 65)
					rle_frame(RLE_CUT, $urandom_range(1, 3));
				else
					rle_frame(RLE_OVERRUN, $urandom_range(0, 2));
			end else begin
				repeat ($urandom_range(1, 2))
					fixed_frame(($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
						$urandom_range(1, 24), $urandom_range(0, 2) != 0);
			end
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0, 1'b0);
		end

		// A whole frame of full-row runs while the pixel side holds off.
		drain();
		sender_idles = 1'b0;
		sink_stalls = 1'b1;
		write_kind(KIND_RLE);
		hold_off_req = 1'b1;
		for (r = 0; r < SIDE; r++)
			send_item(8'(256 - SIDE), r == 0, 1'b0);
		fed_items += SIDE;
		send_item(8'h99, 1'b0, 1'b0);
		drain();

		if (fail_count == 0)
			$display("tile_frame_decoder_unit regression: pass");
		else
			$display("tile_frame_decoder_unit regression: fail");
		$finish;
	end

endmodule

[filelist.f]
rtl/tfd_pkg.sv
rtl/tfd_out_reg.sv
rtl/tile_frame_decoder_unit.sv
bench/tfd_pixel_checker.sv
bench/testbench.sv
